FILE: rtl/sled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg: shared types and constants of the string literal escape decoder
// Phase codes, literal kinds, error codes, the result record and the small
// character helpers used by the step logic.
// ----------------------------------------------------------------------------
package sled_pkg;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_ESC    = 3'd3;
  localparam logic [2:0] PH_OCT    = 3'd4;
  localparam logic [2:0] PH_HEX    = 3'd5;
  localparam logic [2:0] PH_UCN4   = 3'd6;
  localparam logic [2:0] PH_UCN8   = 3'd7;

  localparam logic [2:0] KIND_PLAIN = 3'd0;
  localparam logic [2:0] KIND_L     = 3'd1;
  localparam logic [2:0] KIND_U16   = 3'd2;
  localparam logic [2:0] KIND_U8    = 3'd3;
  localparam logic [2:0] KIND_U32   = 3'd4;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_PREFIX = 2'd1;
  localparam logic [1:0] ERR_UCN    = 2'd2;
  localparam logic [1:0] ERR_ESC    = 2'd3;

  localparam int QueueDepth = 4;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam logic       REG_WIDE_ADDR = 1'b0;

  typedef struct packed {
    logic [31:0] unit_value;
    logic        has_unit;
    logic [2:0]  kind;
    logic        last;
    logic [1:0]  error;
  } res_t;

  typedef struct packed {
    logic [1:0] n_res;
    res_t       res0;
    res_t       res1;
  } step_out_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= "0" && c <= "9") begin
      h.val = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      h.val = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      h.val = 4'(c - "A" + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [31:0] unit_mask(input logic [2:0] kind, input logic wide32);
    logic [31:0] m;
    case (kind)
      KIND_L:   m = wide32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
      KIND_U16: m = 32'h0000_FFFF;
      KIND_U32: m = 32'hFFFF_FFFF;
      default:  m = 32'h0000_00FF;
    endcase
    return m;
  endfunction

  function automatic res_t mk_res(input logic [31:0] val, input logic has,
                                  input logic last, input logic [1:0] err,
                                  input logic [2:0] kind, input logic wide32);
    res_t r;
    r.unit_value = has ? (val & unit_mask(kind, wide32)) : 32'd0;
    r.has_unit   = has;
    r.kind       = kind;
    r.last       = last;
    r.error      = err;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sled_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_ifs: valid/ready channels of the string literal escape decoder
// The byte channel and the result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface sled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface sled_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] unit_value;
  logic        has_unit;
  logic [2:0]  kind;
  logic        last;
  logic [1:0]  error;
  modport source (output valid, output unit_value, output has_unit, output kind,
                  output last, output error, input ready);
  modport sink   (input valid, input unit_value, input has_unit, input kind,
                  input last, input error, output ready);
endinterface
`default_nettype wire

FILE: rtl/sled_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_cfg: configuration register block
// APB-style write/read access to the wide unit width select.
// ----------------------------------------------------------------------------
module sled_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             wide_is_32bit
);

  logic wide_r;
  logic wide_nxt;
  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == sled_pkg::REG_WIDE_ADDR);

  always_comb begin
    wide_nxt = wide_r;
    if (wr_hit) begin
      wide_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b1;
    end else begin
      wide_r <= wide_nxt;
    end
  end

  assign prdata        = (paddr[2] == sled_pkg::REG_WIDE_ADDR) ? {31'd0, wide_r} : 32'd0;
  assign wide_is_32bit = wide_r;

endmodule
`default_nettype wire

FILE: rtl/sled_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_step: decoder state and per-byte step logic
// Holds phase, literal kind, accumulator and digit count, and turns one
// registered byte into zero, one or two results.
// ----------------------------------------------------------------------------
module sled_step (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             process,
  input  wire logic [7:0]       ch,
  input  wire logic             wide_is_32bit,
  output sled_pkg::step_out_t   step_out
);

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  logic [2:0]      body_phase;
  logic            body_emit;
  sled_pkg::res_t  body_res;
  sled_pkg::hex_t  hx;
  logic            is_oct;
  logic [31:0]     oct_acc;
  logic [31:0]     hex_acc;
  logic [3:0]      cnt_inc;
  logic [3:0]      ucn_need;
  sled_pkg::step_out_t so;

  assign hx       = sled_pkg::hex_val(ch);
  assign is_oct   = (ch >= "0") && (ch <= "7");
  assign oct_acc  = {acc_r[28:0], 3'b000} + {29'd0, ch[2:0]};
  assign hex_acc  = {acc_r[27:0], 4'b0000} + {28'd0, hx.val};
  assign cnt_inc  = cnt_r + 4'd1;
  assign ucn_need = (phase_r == sled_pkg::PH_UCN4) ? 4'd4 : 4'd8;

  always_comb begin
    body_phase = sled_pkg::PH_BODY;
    body_emit  = 1'b1;
    body_res   = sled_pkg::mk_res({24'd0, ch}, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                  kind_r, wide_is_32bit);
    if (ch == "\"") begin
      body_phase = sled_pkg::PH_IDLE;
      body_res   = sled_pkg::mk_res(32'd0, 1'b0, 1'b1, sled_pkg::ERR_NONE,
                                    kind_r, wide_is_32bit);
    end else if (ch == "\\") begin
      body_phase = sled_pkg::PH_ESC;
      body_emit  = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    so        = '0;
    case (phase_r)
      sled_pkg::PH_IDLE: begin
        kind_nxt = sled_pkg::KIND_PLAIN;
        case (ch)
          "\"": phase_nxt = sled_pkg::PH_BODY;
          "L": begin
            kind_nxt  = sled_pkg::KIND_L;
            phase_nxt = sled_pkg::PH_PREFIX;
          end
          "u": begin
            kind_nxt  = sled_pkg::KIND_U16;
            phase_nxt = sled_pkg::PH_PREFIX;
          end
          "U": begin
            kind_nxt  = sled_pkg::KIND_U32;
            phase_nxt = sled_pkg::PH_PREFIX;
          end
          default: begin
            so.n_res = 2'd1;
            so.res0  = sled_pkg::mk_res(32'd0, 1'b0, 1'b1, sled_pkg::ERR_PREFIX,
                                        sled_pkg::KIND_PLAIN, wide_is_32bit);
          end
        endcase
      end
      sled_pkg::PH_PREFIX: begin
        if (kind_r == sled_pkg::KIND_U16 && ch == "8") begin
          kind_nxt = sled_pkg::KIND_U8;
        end else begin
          phase_nxt = sled_pkg::PH_BODY;
        end
      end
      sled_pkg::PH_BODY: begin
        phase_nxt = body_phase;
        so.n_res  = {1'b0, body_emit};
        so.res0   = body_res;
      end
      sled_pkg::PH_ESC: begin
        acc_nxt   = 32'd0;
        cnt_nxt   = 4'd0;
        phase_nxt = sled_pkg::PH_BODY;
        so.n_res  = 2'd1;
        if (is_oct) begin
          acc_nxt   = {29'd0, ch[2:0]};
          cnt_nxt   = 4'd1;
          phase_nxt = sled_pkg::PH_OCT;
          so.n_res  = 2'd0;
        end else begin
          case (ch)
            "x": begin
              phase_nxt = sled_pkg::PH_HEX;
              so.n_res  = 2'd0;
            end
            "u": begin
              phase_nxt = sled_pkg::PH_UCN4;
              so.n_res  = 2'd0;
            end
            "U": begin
              phase_nxt = sled_pkg::PH_UCN8;
              so.n_res  = 2'd0;
            end
            "'", "\"", "?", "\\":
              so.res0 = sled_pkg::mk_res({24'd0, ch}, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                         kind_r, wide_is_32bit);
            "a": so.res0 = sled_pkg::mk_res(32'd7, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                            kind_r, wide_is_32bit);
            "b": so.res0 = sled_pkg::mk_res(32'd8, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                            kind_r, wide_is_32bit);
            "f": so.res0 = sled_pkg::mk_res(32'd12, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                            kind_r, wide_is_32bit);
            "n": so.res0 = sled_pkg::mk_res(32'd10, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                            kind_r, wide_is_32bit);
            "r": so.res0 = sled_pkg::mk_res(32'd13, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                            kind_r, wide_is_32bit);
            "t": so.res0 = sled_pkg::mk_res(32'd9, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                            kind_r, wide_is_32bit);
            "v": so.res0 = sled_pkg::mk_res(32'd11, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                            kind_r, wide_is_32bit);
            default: begin
              phase_nxt = sled_pkg::PH_IDLE;
              so.res0   = sled_pkg::mk_res(32'd0, 1'b0, 1'b1, sled_pkg::ERR_ESC,
                                           kind_r, wide_is_32bit);
            end
          endcase
        end
      end
      sled_pkg::PH_OCT, sled_pkg::PH_HEX: begin
        if ((phase_r == sled_pkg::PH_OCT) ? (is_oct && cnt_r < 4'd3)
                                          : (hx.ok && cnt_r < 4'd2)) begin
          acc_nxt = (phase_r == sled_pkg::PH_OCT) ? oct_acc : hex_acc;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ((phase_r == sled_pkg::PH_OCT) ? 4'd3 : 4'd2)) begin
            phase_nxt = sled_pkg::PH_BODY;
            so.n_res  = 2'd1;
            so.res0   = sled_pkg::mk_res(acc_nxt, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                         kind_r, wide_is_32bit);
          end
        end else begin
          phase_nxt = body_phase;
          so.n_res  = body_emit ? 2'd2 : 2'd1;
          so.res0   = sled_pkg::mk_res(acc_r, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                       kind_r, wide_is_32bit);
          so.res1   = body_res;
        end
      end
      default: begin
        if (!hx.ok) begin
          phase_nxt = sled_pkg::PH_IDLE;
          so.n_res  = 2'd1;
          so.res0   = sled_pkg::mk_res(32'd0, 1'b0, 1'b1, sled_pkg::ERR_UCN,
                                       kind_r, wide_is_32bit);
        end else begin
          acc_nxt = hex_acc;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ucn_need) begin
            phase_nxt = sled_pkg::PH_BODY;
            so.n_res  = 2'd1;
            so.res0   = sled_pkg::mk_res(hex_acc, 1'b1, 1'b0, sled_pkg::ERR_NONE,
                                         kind_r, wide_is_32bit);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sled_pkg::PH_IDLE;
      kind_r  <= sled_pkg::KIND_PLAIN;
      acc_r   <= 32'd0;
      cnt_r   <= 4'd0;
    end else if (process) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign step_out = so;

  // An error result always closes the literal.
  assert property (@(posedge clk) disable iff (!rst_n)
    (so.n_res != 2'd0 && so.res0.error != sled_pkg::ERR_NONE) |-> so.res0.last)
    else $error("sled_step: error result without last");

  // A second result only follows a numeric escape unit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (so.n_res == 2'd2) |-> (so.res0.has_unit && !so.res0.last &&
                            (phase_r == sled_pkg::PH_OCT || phase_r == sled_pkg::PH_HEX)))
    else $error("sled_step: unexpected second result");

  // After a closing result the decoder is idle again.
  assert property (@(posedge clk) disable iff (!rst_n)
    (process && so.n_res != 2'd0 && so.res0.last) |=> (phase_r == sled_pkg::PH_IDLE))
    else $error("sled_step: not idle after last");

endmodule
`default_nettype wire

FILE: rtl/sled_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sled_queue: result queue
// Takes up to two results per cycle and hands out one per cycle while it is popped.
// ----------------------------------------------------------------------------
module sled_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        push_n,
  input  wire sled_pkg::res_t    d0,
  input  wire sled_pkg::res_t    d1,
  input  wire logic              pop,
  output logic                   space2,
  output logic                   not_empty,
  output sled_pkg::res_t         head
);

  sled_pkg::res_t                  mem_r [sled_pkg::QueueDepth];
  logic [sled_pkg::PtrW-1:0]       wr_r, wr_nxt;
  logic [sled_pkg::PtrW-1:0]       rd_r, rd_nxt;
  logic [sled_pkg::CntW-1:0]       cnt_r, cnt_nxt;
  logic [sled_pkg::PtrW-1:0]       wr_p1;

  assign wr_p1 = wr_r + sled_pkg::PtrW'(1);

  always_comb begin
    wr_nxt  = wr_r + sled_pkg::PtrW'(push_n);
    rd_nxt  = pop ? rd_r + sled_pkg::PtrW'(1) : rd_r;
    cnt_nxt = cnt_r + sled_pkg::CntW'(push_n) - sled_pkg::CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= d0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_p1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign space2    = cnt_r <= sled_pkg::CntW'(sled_pkg::QueueDepth - 2);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rd_r];

endmodule
`default_nettype wire

FILE: rtl/string_literal_escape_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_escape_decoder: C string literal escape decoder
// Decodes the bytes of C string literals into code units of the literal's
// unit width, with prefix, escape and error handling.
//
//   Channel  Dir  Handshake              Payload
//   in_chan  in   valid/ready            ch
//   out_chan out  valid/ready            unit_value, has_unit, kind, last, error
//   cfg      in   psel/penable/pready    wide_is_32bit at paddr 0 to 3
//
// One byte is accepted per cycle while the queue has room for two results; its
// results pass the input register and the queue, one result per cycle while out ready is high, from a four-entry queue.
// A byte that yields two results takes two queue slots, so a steady run of
// such bytes drains no faster than the single output port hands the results out.
// Reset is synchronous and clears the decoder state and the queue.
// A stalled output fills the queue, then the input register, then in ready drops.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sled_in_if.sink          in_chan,
  sled_out_if.source       out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                vld_r, vld_nxt;
  logic [7:0]          ch_r;
  logic                process;
  logic                space2;
  logic                not_empty;
  logic                wide_is_32bit;
  sled_pkg::step_out_t step_out;
  sled_pkg::res_t      head;

  sled_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .wide_is_32bit (wide_is_32bit)
  );

  assign process       = vld_r && space2;
  assign in_chan.ready = !vld_r || process;

  always_comb begin
    vld_nxt = vld_r;
    if (in_chan.valid && in_chan.ready) begin
      vld_nxt = 1'b1;
    end else if (process) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      ch_r <= in_chan.ch;
    end
  end

  sled_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .process       (process),
    .ch            (ch_r),
    .wide_is_32bit (wide_is_32bit),
    .step_out      (step_out)
  );

  sled_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (process ? step_out.n_res : 2'd0),
    .d0        (step_out.res0),
    .d1        (step_out.res1),
    .pop       (out_chan.valid && out_chan.ready),
    .space2    (space2),
    .not_empty (not_empty),
    .head      (head)
  );

  assign out_chan.valid      = not_empty;
  assign out_chan.unit_value = head.unit_value;
  assign out_chan.has_unit   = head.has_unit;
  assign out_chan.kind       = head.kind;
  assign out_chan.last       = head.last;
  assign out_chan.error      = head.error;

endmodule
`default_nettype wire

FILE: tb/sled_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sled_checker: result predictor and comparator for the escape decoder
// Watches the byte and result channels and the register port, decodes every
// accepted byte request with its own model of the literal state machine, and
// compares each delivered result field by field against the oldest pending
// expectation. The failure count and the number of pending results are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module sled_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sled_in_if               in_mon,
  sled_out_if              out_mon,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fail_count,
  output int               outstanding
);

  logic [2:0]       phase;
  logic [2:0]       lit_kind;
  logic [31:0]      acc;
  logic [3:0]       ndig;
  logic             wide32;
  sled_pkg::res_t   pending_results[$];
  int               nfail;

  function automatic logic [31:0] kind_mask();
    case (lit_kind)
      sled_pkg::KIND_L:   return wide32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
      sled_pkg::KIND_U16: return 32'h0000_FFFF;
      sled_pkg::KIND_U32: return 32'hFFFF_FFFF;
      default:            return 32'h0000_00FF;
    endcase
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic push_res(input logic [31:0] v, input logic has, input logic lst,
                          input logic [1:0] err);
    sled_pkg::res_t r;
    r.unit_value = has ? (v & kind_mask()) : 32'd0;
    r.has_unit   = has;
    r.kind       = lit_kind;
    r.last       = lst;
    r.error      = err;
    pending_results.push_back(r);
  endtask

  task automatic take_body(input logic [7:0] c);
    if (c == "\"") begin
      phase = sled_pkg::PH_IDLE;
      push_res(32'd0, 1'b0, 1'b1, sled_pkg::ERR_NONE);
    end else if (c == "\\") begin
      phase = sled_pkg::PH_ESC;
    end else begin
      phase = sled_pkg::PH_BODY;
      push_res(32'(c), 1'b1, 1'b0, sled_pkg::ERR_NONE);
    end
  endtask

  task automatic decode_byte(input logic [7:0] c);
    int          h;
    logic [31:0] v;
    logic        known;
    logic [3:0]  need;
    h = nibble_of(c);
    case (phase)
      sled_pkg::PH_IDLE: begin
        lit_kind = sled_pkg::KIND_PLAIN;
        if (c == "\"") begin
          phase = sled_pkg::PH_BODY;
        end else if (c == "L") begin
          lit_kind = sled_pkg::KIND_L;
          phase = sled_pkg::PH_PREFIX;
        end else if (c == "u") begin
          lit_kind = sled_pkg::KIND_U16;
          phase = sled_pkg::PH_PREFIX;
        end else if (c == "U") begin
          lit_kind = sled_pkg::KIND_U32;
          phase = sled_pkg::PH_PREFIX;
        end else begin
          push_res(32'd0, 1'b0, 1'b1, sled_pkg::ERR_PREFIX);
        end
      end
      sled_pkg::PH_PREFIX: begin
        if (lit_kind == sled_pkg::KIND_U16 && c == "8") lit_kind = sled_pkg::KIND_U8;
        else phase = sled_pkg::PH_BODY;
      end
      sled_pkg::PH_BODY: take_body(c);
      sled_pkg::PH_ESC: begin
        acc = 32'd0;
        ndig = 4'd0;
        if (c >= "0" && c <= "7") begin
          acc = 32'(c - "0");
          ndig = 4'd1;
          phase = sled_pkg::PH_OCT;
        end else if (c == "x") begin
          phase = sled_pkg::PH_HEX;
        end else if (c == "u") begin
          phase = sled_pkg::PH_UCN4;
        end else if (c == "U") begin
          phase = sled_pkg::PH_UCN8;
        end else begin
          known = 1'b1;
          v = 32'd0;
          case (c)
            "'":     v = 32'd39;
            "\"":    v = 32'd34;
            "?":     v = 32'd63;
            "\\":    v = 32'd92;
            "a":     v = 32'd7;
            "b":     v = 32'd8;
            "f":     v = 32'd12;
            "n":     v = 32'd10;
            "r":     v = 32'd13;
            "t":     v = 32'd9;
            "v":     v = 32'd11;
            default: known = 1'b0;
          endcase
          if (known) begin
            phase = sled_pkg::PH_BODY;
            push_res(v, 1'b1, 1'b0, sled_pkg::ERR_NONE);
          end else begin
            phase = sled_pkg::PH_IDLE;
            push_res(32'd0, 1'b0, 1'b1, sled_pkg::ERR_ESC);
          end
        end
      end
      sled_pkg::PH_OCT: begin
        if (c >= "0" && c <= "7" && ndig < 4'd3) begin
          acc = (acc << 3) + 32'(c - "0");
          ndig = ndig + 4'd1;
          if (ndig >= 4'd3) begin
            phase = sled_pkg::PH_BODY;
            push_res(acc, 1'b1, 1'b0, sled_pkg::ERR_NONE);
          end
        end else begin
          push_res(acc, 1'b1, 1'b0, sled_pkg::ERR_NONE);
          take_body(c);
        end
      end
      sled_pkg::PH_HEX: begin
        if (h >= 0 && ndig < 4'd2) begin
          acc = (acc << 4) + 32'(h);
          ndig = ndig + 4'd1;
          if (ndig >= 4'd2) begin
            phase = sled_pkg::PH_BODY;
            push_res(acc, 1'b1, 1'b0, sled_pkg::ERR_NONE);
          end
        end else begin
          push_res(acc, 1'b1, 1'b0, sled_pkg::ERR_NONE);
          take_body(c);
        end
      end
      default: begin
        need = (phase == sled_pkg::PH_UCN4) ? 4'd4 : 4'd8;
        if (h < 0) begin
          phase = sled_pkg::PH_IDLE;
          push_res(32'd0, 1'b0, 1'b1, sled_pkg::ERR_UCN);
        end else begin
          acc = (acc << 4) + 32'(h);
          ndig = ndig + 4'd1;
          if (ndig >= need) begin
            phase = sled_pkg::PH_BODY;
            push_res(acc, 1'b1, 1'b0, sled_pkg::ERR_NONE);
          end
        end
      end
    endcase
  endtask

  task automatic note_fail(input string msg);
    if (nfail < 10) $display("%s", msg);
    nfail++;
  endtask

  function automatic string res_str(input sled_pkg::res_t r);
    return $sformatf("value=%h has=%b kind=%0d last=%b error=%0d",
                     r.unit_value, r.has_unit, r.kind, r.last, r.error);
  endfunction

  always @(posedge clk) begin
    sled_pkg::res_t got;
    sled_pkg::res_t want;
    if (!rst_n) begin
      phase = sled_pkg::PH_IDLE;
      lit_kind = sled_pkg::KIND_PLAIN;
      acc = 32'd0;
      ndig = 4'd0;
      wide32 = 1'b1;
      nfail = 0;
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == {sled_pkg::REG_WIDE_ADDR, 2'b00}) begin
        wide32 = pwdata[0];
      end
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.ch);
      if (out_mon.valid && out_mon.ready) begin
        got.unit_value = out_mon.unit_value;
        got.has_unit   = out_mon.has_unit;
        got.kind       = out_mon.kind;
        got.last       = out_mon.last;
        got.error      = out_mon.error;
        if (pending_results.size() == 0) begin
          note_fail($sformatf("%0t: unexpected result %s", $realtime, res_str(got)));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            note_fail($sformatf("%0t: mismatch expected %s, got %s", $realtime,
                                res_str(want), res_str(got)));
          end
        end
      end
    end
    fail_count <= nfail;
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/tb_string_literal_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_literal_escape_decoder: testbench top of the escape decoder
// Feeds byte requests for C string literals: a short directed sequence of
// prefixes, escapes and error cases, then random literals of every kind with
// broken endings and noise, under both wide-unit settings. Both channels idle
// at random, and the result side holds off once long enough to back up the
// input. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_string_literal_escape_decoder;

  localparam string HexDigits     = "0123456789abcdefABCDEF";
  localparam string SimpleEscapes = "'\"?\\abfnrtv";
  localparam string NotHex        = "ghGHxz_ -\"\\";
  localparam string NotEscapes    =
    "cdeghijklmopqswyz89!#$%&()*+,-./:;<=>@[]^_{|}~ ABCDEFGHIJKLMNOPQRSTVWXYZ";

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  int          sent_count;
  logic [7:0]  lit_bytes[$];
  logic [7:0]  directed_bytes[$] = '{
    "Q",
    "u", "8", "\"", "\\", "7", "7", "7", "\\", "x", "\"",
    "L", "#", 8'hFF, "\\", "u", "1", "2", "a", "B", "\\", "q",
    "U", "\"", "\\", "u", "1", "g"
  };

  wire quiet = (sent_count >= 150) && (sent_count < 260);

  sled_in_if  in_if ();
  sled_out_if out_if ();

  string_literal_escape_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sled_checker check_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == "\"" || b == "\\");
    return b;
  endfunction

  task automatic write_wide(input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sled_pkg::REG_WIDE_ADDR, 2'b00};
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch <= b;
    do @(posedge clk); while (!in_if.ready);
    sent_count++;
  endtask

  task automatic gen_literal();
    lit_bytes.delete();
    if ($urandom_range(99) < 6) begin
      lit_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(4))
      1: lit_bytes.push_back("L");
      2: lit_bytes.push_back("u");
      3: begin
        lit_bytes.push_back("u");
        lit_bytes.push_back("8");
      end
      4: lit_bytes.push_back("U");
      default: ;
    endcase
    if (lit_bytes.size() != 0 && $urandom_range(9) == 0) lit_bytes.push_back(plain_byte());
    else lit_bytes.push_back("\"");
    repeat ($urandom_range(6)) begin
      case ($urandom_range(9))
        4: begin
          lit_bytes.push_back("\\");
          lit_bytes.push_back(pick(SimpleEscapes));
        end
        5: begin
          lit_bytes.push_back("\\");
          repeat ($urandom_range(1, 3)) lit_bytes.push_back(8'($urandom_range(48, 55)));
        end
        6: begin
          lit_bytes.push_back("\\");
          lit_bytes.push_back("x");
          repeat ($urandom_range(2)) lit_bytes.push_back(pick(HexDigits));
        end
        7: begin
          lit_bytes.push_back("\\");
          lit_bytes.push_back("u");
          repeat (4) lit_bytes.push_back(pick(HexDigits));
        end
        8: begin
          lit_bytes.push_back("\\");
          lit_bytes.push_back("U");
          repeat (8) lit_bytes.push_back(pick(HexDigits));
        end
        9: lit_bytes.push_back(8'($urandom_range(128, 255)));
        default: lit_bytes.push_back(plain_byte());
      endcase
    end
    if ($urandom_range(99) < 8) begin
      lit_bytes.push_back("\\");
      case ($urandom_range(2))
        0: lit_bytes.push_back($urandom_range(1) ? pick(NotEscapes)
                                                 : 8'($urandom_range(128, 255)));
        1: begin
          lit_bytes.push_back("u");
          repeat ($urandom_range(3)) lit_bytes.push_back(pick(HexDigits));
          lit_bytes.push_back(pick(NotHex));
        end
        default: begin
          lit_bytes.push_back("U");
          repeat ($urandom_range(7)) lit_bytes.push_back(pick(HexDigits));
          lit_bytes.push_back(pick(NotHex));
        end
      endcase
    end else begin
      lit_bytes.push_back("\"");
    end
  endtask

  task automatic send_random_until(input int total);
    while (sent_count < total) begin
      gen_literal();
      foreach (lit_bytes[i]) send_byte(lit_bytes[i]);
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  // The result side holds off once for a long stretch to fill the block.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_count >= 400) begin
        held = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 7);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.ch = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    sent_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_wide(1'b1);
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    send_random_until(260);
    wait_drained();
    write_wide(1'b0);
    send_random_until(500);
    wait_drained();
    write_wide(1'b1);
    send_random_until(700);
    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: string_literal_escape_decoder.f
rtl/sled_pkg.sv
rtl/sled_ifs.sv
rtl/sled_cfg.sv
rtl/sled_step.sv
rtl/sled_queue.sv
rtl/string_literal_escape_decoder.sv
tb/sled_checker.sv
tb/tb_string_literal_escape_decoder.sv
